// File: hw/rtl/kht_pkg.sv
// ----------------------------------------------------------------------------
// kht_pkg: shared types and constants of the keyed handle table
// Sizes of the table, operation and status codes, and the payload structs
// of the request and response channels.
// ----------------------------------------------------------------------------
package kht_pkg;

  // table geometry: the bucket count is a power of two, the bucket is the
  // low bits of the key
  localparam int unsigned BktW    = 4;
  localparam int unsigned Buckets = 2 ** BktW;
  localparam int unsigned Ways    = 4;
  localparam int unsigned WayW    = (Ways > 1) ? $clog2(Ways) : 1;

  localparam int unsigned OpW     = 2;
  localparam int unsigned KeyW    = 31;
  localparam int unsigned ValueW  = 64;

  typedef enum logic [OpW-1:0] {
    OpInsert = 2'd0,
    OpRemove = 2'd1,
    OpRecall = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNotFound = 2'd1,
    StDuplicate = 2'd2,
    StFull     = 2'd3
  } status_e;

  typedef struct packed {
    logic [OpW-1:0]    operation;
    logic [KeyW-1:0]   key;
    logic [ValueW-1:0] value;
  } in_t;

  typedef struct packed {
    status_e           status;
    logic [ValueW-1:0] found_value;
  } out_t;

endpackage

// File: hw/rtl/keyed_handle_table.sv
// ----------------------------------------------------------------------------
// keyed_handle_table: set-associative key to handle store
// Insert, remove and recall of keys in a table of buckets with a fixed number
// of ways each; all ways of a bucket are compared together in the same cycle.
// ----------------------------------------------------------------------------
// usage
//   request channel in_valid_i / in_ready_o / in_data_i carries one operation
//   per beat: insert (key, value), remove (key) or recall (key)
//   response channel out_valid_o / out_ready_i / out_data_o returns exactly
//   one beat per request, in request order: a status and, on a successful
//   remove or recall, the stored handle (zero otherwise)
//   the bucket is the low bits of the key; insert takes the lowest free way
//   and fails on a duplicate key or a full bucket
// timing
//   a request beat is registered into the compare stage with its row read;
//   compare and update happen there and the result is registered in out_q
//   throughput: one request per cycle while out_ready_i keeps up; an insert
//   into the bucket being read is forwarded into the read row.
// reset
//   all valid marks are cleared at once, the table is empty right after reset;
//   key and handle storage is not cleared and needs no sweep
// stalls
//   when out_ready_i is low the response waits in the output register, the
//   compare stage holds its request and in_ready_o drops once both are full
// ----------------------------------------------------------------------------
module keyed_handle_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  kht_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output kht_pkg::out_t out_data_o
);

  // storage: one row per bucket, one entry per way
  logic [kht_pkg::Ways-1:0][kht_pkg::KeyW-1:0]   key_mem [kht_pkg::Buckets];
  logic [kht_pkg::Ways-1:0][kht_pkg::ValueW-1:0] val_mem [kht_pkg::Buckets];

  // valid marks live in flops so reset empties the table at once
  logic [kht_pkg::Buckets-1:0][kht_pkg::Ways-1:0] valid_q;

  // compare stage: request plus the row read for its bucket
  logic                                          s1_valid_q;
  kht_pkg::in_t                                  s1_q;
  logic [kht_pkg::Ways-1:0][kht_pkg::KeyW-1:0]   key_row_q;
  logic [kht_pkg::Ways-1:0][kht_pkg::ValueW-1:0] val_row_q;

  // output register
  logic          out_valid_q, out_valid_d;
  kht_pkg::out_t out_q;

  logic                      in_accept;
  logic                      s1_adv;
  logic [kht_pkg::BktW-1:0]  in_bkt;
  logic [kht_pkg::BktW-1:0]  s1_bkt;
  logic [kht_pkg::Ways-1:0]  valid_row;
  logic [kht_pkg::Ways-1:0]  hit_vec;
  logic                      hit_any;
  logic [kht_pkg::WayW-1:0]  hit_way;
  logic                      free_any;
  logic [kht_pkg::WayW-1:0]  free_way;
  logic                      wr_en;
  logic                      clr_en;
  kht_pkg::out_t             res;

  // handshake: compare stage moves on when the output register frees up
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_bkt    = in_data_i.key[kht_pkg::BktW-1:0];
  assign s1_bkt    = s1_q.key[kht_pkg::BktW-1:0];
  assign valid_row = valid_q[s1_bkt];

  // way compare, lowest hit and lowest free way
  always_comb begin
    hit_any  = 1'b0;
    hit_way  = '0;
    free_any = 1'b0;
    free_way = '0;
    for (int w = 0; w < int'(kht_pkg::Ways); w++) begin
      hit_vec[w] = valid_row[w] && (key_row_q[w] == s1_q.key);
    end
    for (int w = int'(kht_pkg::Ways) - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_any = 1'b1;
        hit_way = kht_pkg::WayW'(w);
      end
      if (!valid_row[w]) begin
        free_any = 1'b1;
        free_way = kht_pkg::WayW'(w);
      end
    end
  end

  // operation decode and response
  always_comb begin
    res.status      = kht_pkg::StNotFound;
    res.found_value = '0;
    wr_en           = 1'b0;
    clr_en          = 1'b0;
    case (s1_q.operation)
      kht_pkg::OpInsert: begin
        if (hit_any) begin
          res.status = kht_pkg::StDuplicate;
        end else if (!free_any) begin
          res.status = kht_pkg::StFull;
        end else begin
          res.status = kht_pkg::StOk;
          wr_en      = 1'b1;
        end
      end
      kht_pkg::OpRemove: begin
        if (hit_any) begin
          res.status      = kht_pkg::StOk;
          res.found_value = val_row_q[hit_way];
          clr_en          = 1'b1;
        end
      end
      kht_pkg::OpRecall: begin
        if (hit_any) begin
          res.status      = kht_pkg::StOk;
          res.found_value = val_row_q[hit_way];
        end
      end
      default: begin
        res.status = kht_pkg::StNotFound;
      end
    endcase
  end

  // key and handle storage, row read registered at accept; a write to the
  // same bucket in the same cycle is forwarded into the read row
  always_ff @(posedge clk_i) begin
    if (s1_adv && wr_en) begin
      key_mem[s1_bkt][free_way] <= s1_q.key;
      val_mem[s1_bkt][free_way] <= s1_q.value;
    end
    if (in_accept) begin
      for (int w = 0; w < int'(kht_pkg::Ways); w++) begin
        if (s1_adv && wr_en && (s1_bkt == in_bkt) &&
            (free_way == kht_pkg::WayW'(w))) begin
          key_row_q[w] <= s1_q.key;
          val_row_q[w] <= s1_q.value;
        end else begin
          key_row_q[w] <= key_mem[in_bkt][w];
          val_row_q[w] <= val_mem[in_bkt][w];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (s1_adv && wr_en) begin
        valid_q[s1_bkt][free_way] <= 1'b1;
      end
      if (s1_adv && clr_en) begin
        valid_q[s1_bkt][hit_way] <= 1'b0;
      end
    end
  end

  // compare stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= in_data_i;
    end
  end

  // output register
  always_comb begin
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= res;
    end
  end

`ifndef NO_ASSERTIONS
  // keys are unique within a bucket, so at most one way can hit
  a_hit_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $onehot0(hit_vec))
    else $error("more than one way hit in a bucket");

  // a successful insert leaves its slot marked valid
  a_insert_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && wr_en) |=> valid_q[$past(s1_bkt)][$past(free_way)])
    else $error("inserted slot not marked valid");

  // a successful remove leaves its slot empty
  a_remove_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && clr_en) |=> !valid_q[$past(s1_bkt)][$past(hit_way)])
    else $error("removed slot still marked valid");

  // requests are only refused while both stages are full
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("request refused with room in the pipeline");
`endif

endmodule

// File: bench/keyed_handle_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_handle_table_test: self-checking bench of the keyed handle table
// Drives insert, remove and recall requests over valid/ready, predicts every
// response with a behavioral copy of the bucket/way store and compares the
// status and handle of each response beat in order. Directed corner cases
// come first, then random traffic focused on a few crowded buckets, under
// three idle profiles, one long response stall and a full drain between
// phases.
// ----------------------------------------------------------------------------
module keyed_handle_table_test;

  // code 3 is not a real operation, the block must answer it with not found
  localparam logic [kht_pkg::OpW-1:0] OpUnused = 2'd3;

  localparam int unsigned Slots      = kht_pkg::Buckets * kht_pkg::Ways;
  localparam int unsigned SlotW      = $clog2(Slots);
  localparam int unsigned PoolKeys   = 32;
  localparam int unsigned PoolW      = $clog2(PoolKeys);
  localparam int unsigned PoolGroups = 4;
  localparam int unsigned PhaseItems = 417;
  localparam int unsigned StallLen   = 400;
  localparam int unsigned DrainLen   = 8;
  localparam int unsigned HangLimit  = 4000;

  localparam logic [kht_pkg::KeyW-1:0]   KeyMax = '1;
  localparam logic [kht_pkg::ValueW-1:0] ValMax = '1;

  logic clk;
  logic rst_n = 1'b0;

  // request side
  logic          in_valid = 1'b0;
  logic          in_ready;
  kht_pkg::in_t  in_data  = '0;

  // response side
  logic          out_valid;
  logic          out_ready = 1'b0;
  kht_pkg::out_t out_data;

  // requests waiting for the driver, and responses the block still owes
  kht_pkg::in_t  req_q[$];
  kht_pkg::out_t due_q[$];

  // behavioral copy of the store
  bit                         slot_used   [Slots];
  logic [kht_pkg::KeyW-1:0]   slot_tag    [Slots];
  logic [kht_pkg::ValueW-1:0] slot_handle [Slots];

  // idle profile, set per phase
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;

  // long response stall: the stimulus bumps stall_req, the receiver does the rest
  int unsigned stall_req  = 0;
  int unsigned stall_ack  = 0;
  int unsigned stall_left = 0;

  bit          in_took    = 1'b0;
  int unsigned fail_cnt   = 0;
  int unsigned resp_cnt   = 0;
  int unsigned hang_cnt   = 0;

  logic [kht_pkg::KeyW-1:0] key_pool [PoolKeys];

  keyed_handle_table u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // apply one request to the local store and return the response it owes
  function automatic kht_pkg::out_t lookup_apply(kht_pkg::in_t req);
    logic [SlotW-1:0] base;
    int               hit;
    int               vacant;
    kht_pkg::out_t    res;
    base   = SlotW'((req.key % kht_pkg::Buckets) * kht_pkg::Ways);
    hit    = -1;
    vacant = -1;
    res.status      = kht_pkg::StNotFound;
    res.found_value = '0;
    // all ways at once: first matching valid way, lowest free way
    for (int w = 0; w < kht_pkg::Ways; w++) begin
      if (slot_used[base + SlotW'(w)] && slot_tag[base + SlotW'(w)] == req.key && hit < 0)
        hit = w;
      if (!slot_used[base + SlotW'(w)] && vacant < 0) vacant = w;
    end
    case (req.operation)
      kht_pkg::OpInsert: begin
        if (hit >= 0) begin
          res.status = kht_pkg::StDuplicate;
        end else if (vacant < 0) begin
          res.status = kht_pkg::StFull;
        end else begin
          slot_used[base + SlotW'(vacant)]   = 1'b1;
          slot_tag[base + SlotW'(vacant)]    = req.key;
          slot_handle[base + SlotW'(vacant)] = req.value;
          res.status = kht_pkg::StOk;
        end
      end
      kht_pkg::OpRemove, kht_pkg::OpRecall: begin
        if (hit >= 0) begin
          res.status      = kht_pkg::StOk;
          res.found_value = slot_handle[base + SlotW'(hit)];
          if (req.operation == kht_pkg::OpRemove) slot_used[base + SlotW'(hit)] = 1'b0;
        end
      end
      default: ;  // unused code: not found, store untouched
    endcase
    return res;
  endfunction

  task automatic push_req(logic [kht_pkg::OpW-1:0] op, logic [kht_pkg::KeyW-1:0] key,
                          logic [kht_pkg::ValueW-1:0] value);
    kht_pkg::in_t req;
    req.operation = op;
    req.key       = key;
    req.value     = value;
    req_q.push_back(req);
  endtask

  // random request: mostly pool keys crowded into a few buckets so that
  // hits, duplicates and full buckets are common, some wide random keys
  task automatic push_random();
    int unsigned                pick;
    logic [kht_pkg::OpW-1:0]    op;
    logic [kht_pkg::KeyW-1:0]   key;
    logic [kht_pkg::ValueW-1:0] value;
    pick = $urandom_range(99);
    if (pick < 40)      op = kht_pkg::OpInsert;
    else if (pick < 65) op = kht_pkg::OpRemove;
    else if (pick < 95) op = kht_pkg::OpRecall;
    else                op = OpUnused;
    if ($urandom_range(99) < 85) key = key_pool[PoolW'($urandom_range(PoolKeys - 1))];
    else                         key = kht_pkg::KeyW'($urandom);
    pick = $urandom_range(99);
    if (pick < 10)      value = '0;
    else if (pick < 20) value = ValMax;
    else                value = {$urandom, $urandom};
    push_req(op, key, value);
  endtask

  // sender stops until every queued request has gone out and been answered
  task automatic wait_drained();
    while (req_q.size() != 0 || in_valid || due_q.size() != 0) @(negedge clk);
  endtask

  // request driver: new beat only when the line is free or the last beat was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (req_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= req_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // response ready: random idling, or a long hold-off counted down here
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (stall_ack != stall_req) begin
      stall_ack  = stall_req;
      stall_left = StallLen;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // monitor: check response beats first, then predict for the request beat
  always @(posedge clk) begin
    kht_pkg::out_t want;
    in_took <= in_valid && in_ready && rst_n;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected response beat: status %0d handle %h",
                     out_data.status, out_data.found_value);
        end else begin
          want = due_q.pop_front();
          if (out_data.status !== want.status ||
              out_data.found_value !== want.found_value) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("response %0d: expected status %0d handle %h, got status %0d handle %h",
                       resp_cnt, want.status, want.found_value,
                       out_data.status, out_data.found_value);
          end
          resp_cnt++;
        end
      end
      if (in_valid && in_ready) due_q.push_back(lookup_apply(in_data));
    end
  end

  // hang detector: too many cycles without a beat on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      hang_cnt <= 0;
    end else if (hang_cnt >= HangLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      hang_cnt <= hang_cnt + 1;
    end
  end

  initial begin
    logic [kht_pkg::BktW-1:0] grp_bkt [PoolGroups];
    for (int g = 0; g < PoolGroups; g++)
      grp_bkt[g] = kht_pkg::BktW'($urandom_range(kht_pkg::Buckets - 1));
    // eight keys per crowded bucket, twice the way count, random upper bits
    for (int i = 0; i < PoolKeys; i++) begin
      key_pool[i] = kht_pkg::KeyW'($urandom);
      key_pool[i][kht_pkg::BktW-1:0] = grp_bkt[i % PoolGroups];
    end

    // first profile: sender idles little, receiver a lot
    snd_idle_pct = 36;
    rcv_idle_pct = 70;

    // directed corners, mostly in bucket zero
    push_req(kht_pkg::OpRecall, '0, ValMax);                   // empty table
    push_req(kht_pkg::OpRemove, KeyMax, '0);                   // empty table, top key
    push_req(kht_pkg::OpInsert, '0, '0);                       // zero handle stored
    push_req(kht_pkg::OpRecall, '0, '0);                       // zero handle returned ok
    push_req(kht_pkg::OpInsert, '0, ValMax);                   // duplicate
    push_req(kht_pkg::OpInsert, kht_pkg::KeyW'(kht_pkg::Buckets), ValMax);
    push_req(kht_pkg::OpInsert, kht_pkg::KeyW'(2 * kht_pkg::Buckets), {$urandom, $urandom});
    push_req(kht_pkg::OpInsert, kht_pkg::KeyW'(3 * kht_pkg::Buckets), {$urandom, $urandom});
    push_req(kht_pkg::OpInsert, kht_pkg::KeyW'(4 * kht_pkg::Buckets), ValMax); // bucket full
    // full, top bits set
    push_req(kht_pkg::OpInsert, KeyMax & ~kht_pkg::KeyW'(kht_pkg::Buckets - 1), '0);
    push_req(kht_pkg::OpRemove, kht_pkg::KeyW'(kht_pkg::Buckets), '0); // frees way one
    // lands in way one
    push_req(kht_pkg::OpInsert, KeyMax & ~kht_pkg::KeyW'(kht_pkg::Buckets - 1), ValMax);
    push_req(kht_pkg::OpRecall, KeyMax & ~kht_pkg::KeyW'(kht_pkg::Buckets - 1), '0);
    push_req(OpUnused, '0, ValMax);                            // ignored code
    push_req(kht_pkg::OpRecall, '0, '0);                       // still present
    push_req(kht_pkg::OpInsert, KeyMax, ValMax);
    push_req(kht_pkg::OpRecall, KeyMax, '0);
    push_req(kht_pkg::OpRemove, KeyMax, '0);
    push_req(kht_pkg::OpRecall, KeyMax, '0);                   // gone after remove
    push_req(kht_pkg::OpRemove, kht_pkg::KeyW'(2 * kht_pkg::Buckets), '0);
    push_req(kht_pkg::OpRemove, kht_pkg::KeyW'(3 * kht_pkg::Buckets), '0);
    push_req(kht_pkg::OpRemove, '0, '0);
    push_req(kht_pkg::OpRemove, KeyMax & ~kht_pkg::KeyW'(kht_pkg::Buckets - 1), '0);
    // bucket empty again
    push_req(kht_pkg::OpRecall, kht_pkg::KeyW'(3 * kht_pkg::Buckets), '0);

    // reset held for a stretch of clock edges, released on a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PhaseItems; i++) push_random();
    wait_drained();

    // second profile: roles swapped
    snd_idle_pct = 70;
    rcv_idle_pct = 36;
    for (int i = 0; i < PhaseItems; i++) push_random();
    wait_drained();

    // last profile: no idling, plus one long response stall while the
    // sender keeps offering, so the block backs up and drops in_ready
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    for (int i = 0; i < PhaseItems; i++) push_random();
    stall_req = stall_req + 1;
    wait_drained();

    // let any stray beat show up before the verdict
    repeat (DrainLen) @(posedge clk);
    if (due_q.size() != 0) begin
      $display("%0d responses never arrived", due_q.size());
      fail_cnt += due_q.size();
    end
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: keyed_handle_table.f
hw/rtl/kht_pkg.sv
hw/rtl/keyed_handle_table.sv
bench/keyed_handle_table_test.sv
